[design/afs_pkg.sv]
`timescale 1ns / 1ps
// Package for the alignment flag statistics block.
// Holds the totals numbering and the record structs passed between stages; no dependencies.
package afs_pkg;

  localparam int NUM_TOTALS = 26;
  localparam int IDX_W      = 5;
  localparam int TLEN_W     = 32;
  localparam int BASES_W    = 20;

  typedef enum logic [IDX_W-1:0] {
    T_READS, T_MAPQ0, T_QCFAIL, T_UNMAPPED, T_PROPER, T_SUPP, T_SECONDARY,
    T_PRIMARY, T_PAIRS, T_DUP, T_READ1, T_READ2, T_ONESIDED, T_TWOSIDED,
    T_GOOD, T_SAMEREF, T_SUM_TLEN, T_SUM_TLEN2, T_MISMATCH, T_ALIGNED,
    T_UU, T_MM, T_NN, T_UM, T_UN, T_NM
  } afs_total_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TOTALS - 1);

  typedef struct packed {
    logic [NUM_TOTALS-1:0] bump;
    logic [TLEN_W-1:0]     mag;
    logic [BASES_W-1:0]    nm;
    logic [BASES_W-1:0]    alen;
    logic                  sum_en;
    logic                  bases_en;
    logic                  grp_r1;
    logic                  grp_r2;
    logic                  new_name;
    logic                  last;
  } afs_dec_t;

  typedef struct packed {
    afs_dec_t          dec;
    logic [2*TLEN_W-1:0] sq;
  } afs_inc_t;

endpackage

[design/afs_decode.sv]
`timescale 1ns / 1ps
// Input register and flag decode stages of the alignment flag statistics block.
// Produces per-item counter increments and the squared template length; uses afs_pkg.
module afs_decode
  import afs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [11:0]         in_flags,
  input  logic [7:0]          in_map_quality,
  input  logic                in_same_reference,
  input  logic signed [31:0]  in_template_length,
  input  logic [19:0]         in_mismatches,
  input  logic [19:0]         in_aligned_length,
  input  logic                in_new_name,
  input  logic                in_last_record,
  output logic                s2_valid,
  output afs_inc_t            s2_inc
);

  logic               s0_valid_r;
  logic [11:0]        flags_r;
  logic [7:0]         mapq_r;
  logic               same_ref_r;
  logic [31:0]        tl_r;
  logic [19:0]        nm_r;
  logic [19:0]        alen_r;
  logic               new_name_r;
  logic               last_r;

  logic               s1_valid_r;
  afs_dec_t           dec_r;
  logic               s2_valid_r;
  afs_inc_t           inc_r;

  afs_dec_t           dec_nxt;
  logic [63:0]        sq_nxt;
  logic               prim, pr, r1, r2, u, m, good1, good2;

  always_comb begin
    u     = flags_r[2];
    m     = flags_r[3];
    prim  = !flags_r[11] && !flags_r[8];
    pr    = prim && (flags_r[0] || flags_r[1]);
    r1    = pr && !flags_r[10] && flags_r[6];
    r2    = pr && !flags_r[10] && !flags_r[6] && flags_r[7];
    good1 = r1 && !u && !m;
    good2 = r2 && !u && !m;

    dec_nxt = '0;
    dec_nxt.bump[T_READS]     = 1'b1;
    dec_nxt.bump[T_MAPQ0]     = (mapq_r == 8'd0);
    dec_nxt.bump[T_QCFAIL]    = flags_r[9];
    dec_nxt.bump[T_UNMAPPED]  = u;
    dec_nxt.bump[T_PROPER]    = flags_r[1];
    dec_nxt.bump[T_SUPP]      = flags_r[11];
    dec_nxt.bump[T_SECONDARY] = !flags_r[11] && flags_r[8];
    dec_nxt.bump[T_PRIMARY]   = prim;
    dec_nxt.bump[T_PAIRS]     = pr;
    dec_nxt.bump[T_DUP]       = pr && flags_r[10];
    dec_nxt.bump[T_READ1]     = r1;
    dec_nxt.bump[T_READ2]     = r2;
    dec_nxt.bump[T_ONESIDED]  = r1 && (u ^ m);
    dec_nxt.bump[T_TWOSIDED]  = r1 && u && m;
    dec_nxt.bump[T_GOOD]      = good1;
    dec_nxt.bump[T_SAMEREF]   = good1 && same_ref_r;
    dec_nxt.mag      = tl_r[31] ? (~tl_r + 32'd1) : tl_r;
    dec_nxt.nm       = nm_r;
    dec_nxt.alen     = alen_r;
    dec_nxt.sum_en   = good1 && same_ref_r;
    dec_nxt.bases_en = good1 || good2;
    dec_nxt.grp_r1   = !flags_r[11] && !u && flags_r[6];
    dec_nxt.grp_r2   = !flags_r[11] && !u && flags_r[7];
    dec_nxt.new_name = new_name_r;
    dec_nxt.last     = last_r;
  end

  assign sq_nxt = 64'(dec_r.mag) * 64'(dec_r.mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags_r    <= in_flags;
      mapq_r     <= in_map_quality;
      same_ref_r <= in_same_reference;
      tl_r       <= in_template_length;
      nm_r       <= in_mismatches;
      alen_r     <= in_aligned_length;
      new_name_r <= in_new_name;
      last_r     <= in_last_record;
      dec_r      <= dec_nxt;
      inc_r.dec  <= dec_r;
      inc_r.sq   <= sq_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_inc   = inc_r;

endmodule

[design/afs_accum.sv]
`timescale 1ns / 1ps
// Saturating totals bank and name-group classifier of the alignment flag statistics block.
// Adds each item's increments and hands the final totals on the last record; uses afs_pkg.
module afs_accum
  import afs_pkg::*;
#(
  parameter int COUNTER_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   s2_valid,
  input  afs_inc_t                               s2_inc,
  input  logic                                   name_sorted,
  output logic                                   load,
  output logic [NUM_TOTALS-1:0][COUNTER_BITS-1:0] totals
);

  localparam logic [64:0] CNT_MAX = (65'd1 << COUNTER_BITS) - 65'd1;

  logic [NUM_TOTALS-1:0][COUNTER_BITS-1:0] bank_r;
  logic [NUM_TOTALS-1:0][COUNTER_BITS-1:0] bank_nxt;
  logic [NUM_TOTALS-1:0][63:0]             incr;
  logic [1:0]  g1_r, g2_r;
  logic        open_r;
  logic [1:0]  base1, base2, g1_nxt, g2_nxt;
  logic        close1, close2;
  afs_total_t  cls1, cls2;
  logic        step;

  function automatic logic [COUNTER_BITS-1:0] sat_add(input logic [COUNTER_BITS-1:0] cur,
                                                      input logic [63:0] v);
    logic [64:0] sum;
    sum = 65'(cur) + 65'(v);
    if (sum > CNT_MAX) begin
      return '1;
    end
    return sum[COUNTER_BITS-1:0];
  endfunction

  function automatic afs_total_t classify(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = 3'(a) + 3'(b);
    if (a == 2'd1 && b == 2'd1) begin
      return T_UU;
    end else if (a == 2'd2 && b == 2'd2) begin
      return T_MM;
    end else if (a == 2'd0 && b == 2'd0) begin
      return T_NN;
    end else if (s == 3'd3) begin
      return T_UM;
    end else if (s == 3'd1) begin
      return T_UN;
    end
    return T_NM;
  endfunction

  assign step = adv && s2_valid;
  assign load = step && s2_inc.dec.last;

  always_comb begin
    close1 = name_sorted && open_r && s2_inc.dec.new_name;
    close2 = name_sorted && s2_inc.dec.last;
    base1  = close1 ? 2'd0 : g1_r;
    base2  = close1 ? 2'd0 : g2_r;
    g1_nxt = base1 + 2'((s2_inc.dec.grp_r1 && base1 != 2'd2) ? 1 : 0);
    g2_nxt = base2 + 2'((s2_inc.dec.grp_r2 && base2 != 2'd2) ? 1 : 0);
    cls1   = classify(g1_r, g2_r);
    cls2   = classify(g1_nxt, g2_nxt);

    for (int i = 0; i < NUM_TOTALS; i++) begin
      incr[i] = {63'd0, s2_inc.dec.bump[i]};
    end
    incr[T_SUM_TLEN]  = s2_inc.dec.sum_en ? 64'(s2_inc.dec.mag) : 64'd0;
    incr[T_SUM_TLEN2] = s2_inc.dec.sum_en ? s2_inc.sq : 64'd0;
    incr[T_MISMATCH]  = s2_inc.dec.bases_en ? 64'(s2_inc.dec.nm) : 64'd0;
    incr[T_ALIGNED]   = s2_inc.dec.bases_en ? 64'(s2_inc.dec.alen) : 64'd0;
    for (int k = T_UU; k <= T_NM; k++) begin
      incr[k] = 64'((close1 && cls1 == afs_total_t'(k)) ? 1 : 0)
              + 64'((close2 && cls2 == afs_total_t'(k)) ? 1 : 0);
    end

    for (int i = 0; i < NUM_TOTALS; i++) begin
      bank_nxt[i] = sat_add(bank_r[i], incr[i]);
    end
  end

  assign totals = bank_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= '0;
      g1_r   <= 2'd0;
      g2_r   <= 2'd0;
      open_r <= 1'b0;
    end else if (step) begin
      if (s2_inc.dec.last) begin
        bank_r <= '0;
        g1_r   <= 2'd0;
        g2_r   <= 2'd0;
        open_r <= 1'b0;
      end else begin
        bank_r <= bank_nxt;
        if (name_sorted) begin
          g1_r   <= g1_nxt;
          g2_r   <= g2_nxt;
          open_r <= 1'b1;
        end
      end
    end
  end

endmodule

[design/afs_dump.sv]
`timescale 1ns / 1ps
// Result shift line of the alignment flag statistics block.
// Holds a snapshot of all totals and presents them one item per cycle while out_ready is high; uses afs_pkg.
module afs_dump
  import afs_pkg::*;
#(
  parameter int COUNTER_BITS = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    load,
  input  logic [NUM_TOTALS-1:0][COUNTER_BITS-1:0] vals,
  output logic                                    free,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [4:0]                              out_counter_index,
  output logic [63:0]                             out_counter_value,
  output logic                                    out_last_total
);

  logic                                    busy_r;
  logic [IDX_W-1:0]                        idx_r;
  logic [NUM_TOTALS-1:0][COUNTER_BITS-1:0] line_r;
  logic                                    fire;
  logic                                    at_last;

  assign fire    = busy_r && out_ready;
  assign at_last = (idx_r == LAST_IDX);
  assign free    = !busy_r || (fire && at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      idx_r <= idx_r + IDX_W'(1);
      if (at_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_TOTALS; i++) begin
        line_r[i] <= (i == T_PAIRS) ? (vals[i] >> 1) : vals[i];
      end
    end else if (fire) begin
      for (int i = 0; i < NUM_TOTALS - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
    end
  end

  assign out_valid         = busy_r;
  assign out_counter_index = idx_r;
  assign out_counter_value = 64'(line_r[0]);
  assign out_last_total    = busy_r && at_last;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("totals loaded while a dump is still in progress");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= LAST_IDX)
    else $error("dump index beyond the last total");

  a_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy_r) |-> $past(idx_r) == LAST_IDX)
    else $error("dump ended before the last total");

endmodule

[design/alignment_flag_statistics.sv]
`timescale 1ns / 1ps
// Alignment flag statistics: one record per cycle, 26 totals dumped on the last record.
// A last record passes the input, decode and increment registers, then loads the dump.
// Throughput: one record per cycle; a dump gives one total per cycle while out_ready is high, via a shift line.
// A last record reaching the bank stalls input only while an earlier dump is still pending.
// Synchronous active-low reset clears totals, group state, name_sorted and all valid flags.
module alignment_flag_statistics
  import afs_pkg::*;
#(
  parameter int COUNTER_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_flags,
  input  logic [7:0]         in_map_quality,
  input  logic               in_same_reference,
  input  logic signed [31:0] in_template_length,
  input  logic [19:0]        in_mismatches,
  input  logic [19:0]        in_aligned_length,
  input  logic               in_new_name,
  input  logic               in_last_record,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_counter_index,
  output logic [63:0]        out_counter_value,
  output logic               out_last_total
);

  logic                                    name_sorted_r;
  logic                                    adv;
  logic                                    s2_valid;
  afs_inc_t                                s2_inc;
  logic                                    load;
  logic                                    free;
  logic [NUM_TOTALS-1:0][COUNTER_BITS-1:0] totals;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_sorted_r <= 1'b0;
    end else if (cfg_we) begin
      name_sorted_r <= cfg_wdata;
    end
  end

  assign adv      = !(s2_valid && s2_inc.dec.last && !free);
  assign in_ready = adv;

  afs_decode u_decode (
    .clk                (clk),
    .rst_n              (rst_n),
    .adv                (adv),
    .in_valid           (in_valid),
    .in_flags           (in_flags),
    .in_map_quality     (in_map_quality),
    .in_same_reference  (in_same_reference),
    .in_template_length (in_template_length),
    .in_mismatches      (in_mismatches),
    .in_aligned_length  (in_aligned_length),
    .in_new_name        (in_new_name),
    .in_last_record     (in_last_record),
    .s2_valid           (s2_valid),
    .s2_inc             (s2_inc)
  );

  afs_accum #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .s2_valid    (s2_valid),
    .s2_inc      (s2_inc),
    .name_sorted (name_sorted_r),
    .load        (load),
    .totals      (totals)
  );

  afs_dump #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dump (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .vals              (totals),
    .free              (free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_counter_index (out_counter_index),
    .out_counter_value (out_counter_value),
    .out_last_total    (out_last_total)
  );

endmodule

[tb/afs_tb_pkg.sv]
`timescale 1ns / 1ps
// SAM flag bit names shared by the alignment flag statistics testbench files.
// No dependencies.
package afs_tb_pkg;

  localparam logic [11:0] FLAG_PAIRED    = 12'h001;
  localparam logic [11:0] FLAG_PROPER    = 12'h002;
  localparam logic [11:0] FLAG_UNMAP     = 12'h004;
  localparam logic [11:0] FLAG_MUNMAP    = 12'h008;
  localparam logic [11:0] FLAG_READ1     = 12'h040;
  localparam logic [11:0] FLAG_READ2     = 12'h080;
  localparam logic [11:0] FLAG_SECONDARY = 12'h100;
  localparam logic [11:0] FLAG_QCFAIL    = 12'h200;
  localparam logic [11:0] FLAG_DUP       = 12'h400;
  localparam logic [11:0] FLAG_SUPP      = 12'h800;
  localparam logic [11:0] FLAG_ALL       = 12'hFFF;

endpackage

[tb/alignment_flag_statistics_chk.sv]
`timescale 1ns / 1ps
// Checker for alignment_flag_statistics: tallies every accepted record into its own counter
// bank, queues the 26 totals of each dump and compares them with the output channel.
// Depends on afs_pkg and afs_tb_pkg.
module alignment_flag_statistics_chk
  import afs_pkg::*;
  import afs_tb_pkg::*;
#(
  parameter int COUNTER_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [11:0] in_flags,
  input  logic [7:0]  in_map_quality,
  input  logic        in_same_reference,
  input  logic [31:0] in_template_length,
  input  logic [19:0] in_mismatches,
  input  logic [19:0] in_aligned_length,
  input  logic        in_new_name,
  input  logic        in_last_record,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  out_counter_index,
  input  logic [63:0] out_counter_value,
  input  logic        out_last_total,
  output int          fail_count,
  output int          totals_due_count
);

  localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - COUNTER_BITS);

  typedef struct packed {
    afs_total_t  index;
    logic [63:0] value;
    logic        last_total;
  } total_rec_t;

  total_rec_t  totals_due[$];
  total_rec_t  want;
  logic [63:0] totals [NUM_TOTALS];
  logic        grouping_on;
  logic [1:0]  r1_hits;
  logic [1:0]  r2_hits;
  logic        group_active;
  int          mismatch_count = 0;

  assign fail_count = mismatch_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    if (mismatch_count < 200) begin
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, wanted);
    end
    mismatch_count++;
  endtask

  task automatic bump(input afs_total_t idx, input logic [63:0] v);
    logic [63:0] cur;
    cur = totals[idx] & CNT_MAX;
    if (v > CNT_MAX || cur > CNT_MAX - v) begin
      totals[idx] = CNT_MAX;
    end else begin
      totals[idx] = cur + v;
    end
  endtask

  task automatic close_group();
    int a;
    int b;
    a = r1_hits;
    b = r2_hits;
    if (a == 1 && b == 1) begin
      bump(T_UU, 1);
    end else if (a == 2 && b == 2) begin
      bump(T_MM, 1);
    end else if (a == 0 && b == 0) begin
      bump(T_NN, 1);
    end else if (a + b == 3) begin
      bump(T_UM, 1);
    end else if (a + b == 1) begin
      bump(T_UN, 1);
    end else begin
      bump(T_NM, 1);
    end
    r1_hits = 2'd0;
    r2_hits = 2'd0;
  endtask

  task automatic dump_totals();
    total_rec_t rec;
    for (int i = 0; i < NUM_TOTALS; i++) begin
      rec.index      = afs_total_t'(i);
      rec.value      = totals[i] & CNT_MAX;
      if (rec.index == T_PAIRS) begin
        rec.value = rec.value >> 1;
      end
      rec.last_total = (rec.index == LAST_IDX);
      totals_due.insert(totals_due.size(), rec);
      totals[i] = '0;
    end
    r1_hits      = 2'd0;
    r2_hits      = 2'd0;
    group_active = 1'b0;
  endtask

  task automatic tally_record(input logic [11:0] fl, input logic [7:0] mq, input logic sr,
                              input logic [31:0] tl, input logic [19:0] nm,
                              input logic [19:0] al, input logic nn, input logic is_last);
    logic        good1;
    logic        good2;
    logic        u;
    logic        m;
    logic [31:0] mag;
    good1 = 1'b0;
    good2 = 1'b0;
    u     = |(fl & FLAG_UNMAP);
    m     = |(fl & FLAG_MUNMAP);
    bump(T_READS, 1);
    if (mq == 8'd0) bump(T_MAPQ0, 1);
    if (|(fl & FLAG_QCFAIL)) bump(T_QCFAIL, 1);
    if (u) bump(T_UNMAPPED, 1);
    if (|(fl & FLAG_PROPER)) bump(T_PROPER, 1);
    if (|(fl & FLAG_SUPP)) begin
      bump(T_SUPP, 1);
    end else if (|(fl & FLAG_SECONDARY)) begin
      bump(T_SECONDARY, 1);
    end else begin
      bump(T_PRIMARY, 1);
      if (|(fl & (FLAG_PAIRED | FLAG_PROPER))) begin
        bump(T_PAIRS, 1);
        if (|(fl & FLAG_DUP)) begin
          bump(T_DUP, 1);
        end else if (|(fl & FLAG_READ1)) begin
          bump(T_READ1, 1);
          if (u != m) begin
            bump(T_ONESIDED, 1);
          end else if (u && m) begin
            bump(T_TWOSIDED, 1);
          end
          if (!u && !m) begin
            good1 = 1'b1;
            bump(T_GOOD, 1);
          end
        end else if (|(fl & FLAG_READ2)) begin
          bump(T_READ2, 1);
          good2 = !u && !m;
        end
      end
    end
    if (good1 && sr) begin
      mag = tl[31] ? (~tl + 32'd1) : tl;
      bump(T_SAMEREF, 1);
      bump(T_SUM_TLEN, 64'(mag));
      bump(T_SUM_TLEN2, 64'(mag) * 64'(mag));
    end
    if (good1 || good2) begin
      bump(T_MISMATCH, 64'(nm));
      bump(T_ALIGNED, 64'(al));
    end
    if (grouping_on) begin
      if (group_active && nn) close_group();
      group_active = 1'b1;
      if (!(|(fl & (FLAG_SUPP | FLAG_UNMAP)))) begin
        if (|(fl & FLAG_READ1) && r1_hits < 2'd2) r1_hits = r1_hits + 2'd1;
        if (|(fl & FLAG_READ2) && r2_hits < 2'd2) r2_hits = r2_hits + 2'd1;
      end
      if (is_last) begin
        close_group();
        group_active = 1'b0;
      end
    end
    if (is_last) dump_totals();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TOTALS; i++) totals[i] = '0;
      grouping_on  = 1'b0;
      r1_hits      = 2'd0;
      r2_hits      = 2'd0;
      group_active = 1'b0;
      totals_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (totals_due.size() == 0) begin
          report_mismatch("total with none expected", 64'(out_counter_index), '0);
        end else begin
          want = totals_due.pop_front();
          if (out_counter_index !== want.index) begin
            report_mismatch("counter index", 64'(out_counter_index), 64'(want.index));
          end
          if (out_counter_value !== want.value) begin
            report_mismatch($sformatf("value of total %0d", want.index),
                            out_counter_value, want.value);
          end
          if (out_last_total !== want.last_total) begin
            report_mismatch($sformatf("last flag of total %0d", want.index),
                            64'(out_last_total), 64'(want.last_total));
          end
        end
      end
      if (cfg_we) grouping_on = cfg_wdata;
      if (in_valid && in_ready) begin
        tally_record(in_flags, in_map_quality, in_same_reference, in_template_length,
                     in_mismatches, in_aligned_length, in_new_name, in_last_record);
      end
    end
    totals_due_count <= totals_due.size();
  end

endmodule

[tb/alignment_flag_statistics_tb.sv]
`timescale 1ns / 1ps
// Testbench top for alignment_flag_statistics: drives records and the grouping register,
// paces the output channel and gives the verdict. Depends on afs_tb_pkg, the checker and the design top.
module alignment_flag_statistics_tb;
  import afs_tb_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 12;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] in_flags;
  logic [7:0]  in_map_quality;
  logic        in_same_reference;
  logic [31:0] in_template_length;
  logic [19:0] in_mismatches;
  logic [19:0] in_aligned_length;
  logic        in_new_name;
  logic        in_last_record;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_counter_index;
  logic [63:0] out_counter_value;
  logic        out_last_total;

  int   fail_count;
  int   totals_due_count;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   records_taken = 0;
  int   totals_taken  = 0;
  int   stall_cycles  = 0;
  logic hold_request  = 1'b0;
  logic hold_off      = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  alignment_flag_statistics u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_flags          (in_flags),
    .in_map_quality    (in_map_quality),
    .in_same_reference (in_same_reference),
    .in_template_length(in_template_length),
    .in_mismatches     (in_mismatches),
    .in_aligned_length (in_aligned_length),
    .in_new_name       (in_new_name),
    .in_last_record    (in_last_record),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_counter_index (out_counter_index),
    .out_counter_value (out_counter_value),
    .out_last_total    (out_last_total)
  );

  alignment_flag_statistics_chk u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_flags          (in_flags),
    .in_map_quality    (in_map_quality),
    .in_same_reference (in_same_reference),
    .in_template_length(in_template_length),
    .in_mismatches     (in_mismatches),
    .in_aligned_length (in_aligned_length),
    .in_new_name       (in_new_name),
    .in_last_record    (in_last_record),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_counter_index (out_counter_index),
    .out_counter_value (out_counter_value),
    .out_last_total    (out_last_total),
    .fail_count        (fail_count),
    .totals_due_count  (totals_due_count)
  );

  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (in_valid && in_ready) records_taken <= records_taken + 1;
    if (out_valid && out_ready) totals_taken <= totals_taken + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("alignment_flag_statistics_tb NOT OK");
      $finish;
    end
  end

  task automatic send_record(input logic [11:0] fl, input logic [7:0] mq, input logic sr,
                             input logic [31:0] tl, input logic [19:0] nm,
                             input logic [19:0] al, input logic nn, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_flags           <= fl;
    in_map_quality     <= mq;
    in_same_reference  <= sr;
    in_template_length <= tl;
    in_mismatches      <= nm;
    in_aligned_length  <= al;
    in_new_name        <= nn;
    in_last_record     <= is_last;
    in_valid           <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (totals_due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_grouping(input logic on);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [11:0] random_flags();
    logic [11:0] fl;
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    fl = FLAG_PAIRED | ($urandom_range(0, 1) ? FLAG_READ2 : FLAG_READ1);
    if ($urandom_range(0, 19) == 0) fl = fl | FLAG_READ1 | FLAG_READ2;
    if ($urandom_range(0, 2) == 0) fl = fl | FLAG_PROPER;
    if ($urandom_range(0, 4) == 0) fl = fl | FLAG_UNMAP;
    if ($urandom_range(0, 4) == 0) fl = fl | FLAG_MUNMAP;
    if ($urandom_range(0, 9) == 0) fl = fl | FLAG_SECONDARY;
    if ($urandom_range(0, 9) == 0) fl = fl | FLAG_SUPP;
    if ($urandom_range(0, 9) == 0) fl = fl | FLAG_DUP;
    if ($urandom_range(0, 9) == 0) fl = fl | FLAG_QCFAIL;
    return fl;
  endfunction

  function automatic logic [31:0] random_tlen();
    int v;
    case ($urandom_range(0, 7))
      0: return 32'($urandom);
      1: return 32'h8000_0000;
      default: begin
        v = $urandom_range(0, 800);
        return $urandom_range(0, 1) ? 32'(-v) : 32'(v);
      end
    endcase
  endfunction

  function automatic logic [19:0] random_bases();
    return ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 150));
  endfunction

  task automatic send_random_stream(input int len);
    int          group_left;
    logic        nn;
    logic [7:0]  mq;
    group_left = 0;
    for (int k = 0; k < len; k++) begin
      if (group_left == 0) begin
        nn         = 1'b1;
        group_left = $urandom_range(1, 4);
      end else begin
        nn = ($urandom_range(0, 19) == 0);
      end
      group_left--;
      mq = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
      send_record(random_flags(), mq, 1'($urandom_range(0, 1)), random_tlen(),
                  random_bases(), random_bases(), nn, k == len - 1);
    end
  endtask

  task automatic run_stage(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_stream(len);
      sent += len;
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 1'b0;
    in_valid           = 1'b0;
    in_flags           = '0;
    in_map_quality     = '0;
    in_same_reference  = 1'b0;
    in_template_length = '0;
    in_mismatches      = '0;
    in_aligned_length  = '0;
    in_new_name        = 1'b0;
    in_last_record     = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed stream with grouping on: flag classes, saturation of the squared sum and
    // at least one name group of each pair class.
    set_grouping(1'b1);
    send_record('0, 8'd0, 1'b0, '0, '0, '0, 1'b1, 1'b0);
    repeat (4) begin
      send_record(FLAG_PAIRED | FLAG_PROPER | FLAG_READ1, 8'd60, 1'b1, 32'h8000_0000,
                  20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0);
    end
    send_record(FLAG_PAIRED | FLAG_PROPER | FLAG_READ2, 8'd60, 1'b1, 32'h7FFF_FFFF,
                20'd5, 20'd100, 1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_PROPER | FLAG_READ1, 8'd30, 1'b1, 32'd250, 20'd1,
                20'd150, 1'b1, 1'b0);
    send_record(FLAG_PAIRED | FLAG_PROPER | FLAG_READ1, 8'd30, 1'b1, -32'sd250, 20'd2,
                20'd150, 1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_READ2, 8'd30, 1'b0, 32'd9, 20'd3, 20'd150, 1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_READ2, 8'd30, 1'b1, 32'd9, 20'd4, 20'd150, 1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_UNMAP | FLAG_MUNMAP | FLAG_READ1, 8'd0, 1'b1, '0, '0,
                '0, 1'b1, 1'b0);
    send_record(FLAG_PAIRED | FLAG_UNMAP | FLAG_MUNMAP | FLAG_READ2, 8'd0, 1'b1, '0, '0,
                '0, 1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_READ1 | FLAG_READ2, 8'd12, 1'b1, 32'd77, 20'd6, 20'd90,
                1'b1, 1'b0);
    send_record(FLAG_PAIRED | FLAG_READ1, 8'd12, 1'b1, 32'd77, 20'd6, 20'd90, 1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_UNMAP | FLAG_READ1, 8'd0, 1'b0, '0, '0, '0, 1'b1, 1'b0);
    send_record(FLAG_PAIRED | FLAG_MUNMAP | FLAG_READ2, 8'd40, 1'b0, '0, 20'd7, 20'd80,
                1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_MUNMAP | FLAG_READ2, 8'd40, 1'b0, '0, 20'd7, 20'd80,
                1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_SUPP | FLAG_READ1, 8'd50, 1'b1, 32'd40, 20'd1, 20'd40,
                1'b1, 1'b0);
    send_record(FLAG_PAIRED | FLAG_SECONDARY | FLAG_READ1, 8'd50, 1'b1, 32'd40, 20'd1,
                20'd40, 1'b0, 1'b0);
    send_record(FLAG_PAIRED | FLAG_QCFAIL | FLAG_DUP | FLAG_READ1, 8'd20, 1'b1, 32'd60,
                20'd1, 20'd60, 1'b1, 1'b0);
    send_record(FLAG_PROPER, 8'hFF, 1'b1, 32'd60, 20'd1, 20'd60, 1'b0, 1'b0);
    send_record(FLAG_ALL, 8'hFF, 1'b1, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0);
    send_record('0, 8'd1, 1'b0, '0, '0, '0, 1'b0, 1'b1);

    send_idle_pct = 18;
    recv_idle_pct = 84;
    set_grouping(1'b0);
    run_stage(90);

    send_idle_pct = 84;
    recv_idle_pct = 18;
    set_grouping(1'b1);
    run_stage(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grouping(1'b0);
    run_stage(30);
    set_grouping(1'b1);
    hold_request = 1'b1;
    wait (hold_off);
    @(negedge clk);
    repeat (12) send_random_stream(3);
    run_stage(30);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run took %0d records and %0d totals with grouping on and off, three pacing mixes",
             records_taken, totals_taken);
    $display("and one long output hold-off that backed up the record input.");
    if (fail_count == 0) begin
      $display("alignment_flag_statistics_tb OK");
    end else begin
      $display("alignment_flag_statistics_tb NOT OK");
    end
    $finish;
  end

endmodule
